// File: rtl/lgse_pkg.sv
// ----------------------------------------------------------------------------
// lgse_pkg
// Shared types and constants of the life grid step engine: command codes,
// fixed field widths and the neighbor counts of the life rule.
// ----------------------------------------------------------------------------
`default_nettype none

package lgse_pkg;

  localparam int CMD_W = 3;
  localparam int COL_W = 6;
  localparam int ROW_W = 5;

  // Width of an eight-neighbor count
  localparam int NBR_W = 4;

  localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [NBR_W-1:0] KEEP_COUNT  = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_TOGGLE  = 3'd1,
    CMD_SET     = 3'd2,
    CMD_ADVANCE = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/lgse_row_mem.sv
// ----------------------------------------------------------------------------
// lgse_row_mem
// Grid storage, one word per grid row. One write port and one read port,
// read data registered and held while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module lgse_row_mem #(
  parameter int ROWS = 32,
  parameter int COLS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [$clog2(ROWS)-1:0]   wr_addr,
  input  wire logic [COLS-1:0]           wr_data,
  input  wire logic                      rd_en,
  input  wire logic [$clog2(ROWS)-1:0]   rd_addr,
  output logic      [COLS-1:0]           rd_data
);

  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lgse_row_gen.sv
// ----------------------------------------------------------------------------
// lgse_row_gen
// Next generation of one grid row from the old row and its two neighbor
// rows. Columns wrap at the edges.
// ----------------------------------------------------------------------------
`default_nettype none

module lgse_row_gen #(
  parameter int COLS = 64
) (
  input  wire logic [COLS-1:0] row_up,
  input  wire logic [COLS-1:0] row_mid,
  input  wire logic [COLS-1:0] row_dn,
  output logic      [COLS-1:0] row_next
);

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    localparam int CL = (c == 0) ? COLS - 1 : c - 1;
    localparam int CR = (c == COLS - 1) ? 0 : c + 1;

    logic [lgse_pkg::NBR_W-1:0] nbr;

    assign nbr = lgse_pkg::NBR_W'(row_up[CL]) + lgse_pkg::NBR_W'(row_up[c])
               + lgse_pkg::NBR_W'(row_up[CR]) + lgse_pkg::NBR_W'(row_mid[CL])
               + lgse_pkg::NBR_W'(row_mid[CR]) + lgse_pkg::NBR_W'(row_dn[CL])
               + lgse_pkg::NBR_W'(row_dn[c]) + lgse_pkg::NBR_W'(row_dn[CR]);

    assign row_next[c] = (nbr == lgse_pkg::BIRTH_COUNT)
                       | ((nbr == lgse_pkg::KEEP_COUNT) & row_mid[c]);
  end

endmodule

`default_nettype wire

// File: rtl/life_grid_step_engine.sv
// ----------------------------------------------------------------------------
// life_grid_step_engine
// Toroidal life grid with clear, toggle, set, read and advance commands.
//
// A command word enters on cmd_valid/cmd_ready; each command returns one
// word on res_valid/res_ready carrying cell_state. One command is worked on
// at a time; cmd_ready is high while the engine is idle, even when an
// earlier result still waits in the output register.
// Steps from accept to the result register:
//   toggle, set, read in range: row read, then S_EDIT
//   out of range or unknown: straight to S_DONE
//   clear:   one row zeroed per cycle
//   advance: rows stream through a three-row window;
//            the row memory reads one row and writes one row per cycle.
// cmd_ready rises again once the result register loads.
// After reset the engine zeroes the grid, one row per cycle, with cmd_ready low.
// If the receiver stalls, a finished result waits until the output
// register is free and the engine holds in its last step meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_step_engine #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire logic [lgse_pkg::CMD_W-1:0]  cmd,
  input  wire logic [lgse_pkg::COL_W-1:0]  col,
  input  wire logic [lgse_pkg::ROW_W-1:0]  row,
  input  wire logic                        value,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic                             cell_state
);

  localparam int RW  = $clog2(GRID_ROWS);
  localparam int CW  = $clog2(GRID_COLS);
  localparam int TW  = $clog2(GRID_ROWS + 4);
  localparam int RXW = (RW > lgse_pkg::ROW_W) ? RW : lgse_pkg::ROW_W;
  localparam int CXW = (CW > lgse_pkg::COL_W) ? CW : lgse_pkg::COL_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EDIT,
    S_STEP,
    S_DONE
  } state_t;

  state_t               state;
  logic [TW-1:0]        t;
  logic                 clr_cmd;
  lgse_pkg::cmd_t       edit_cmd;
  logic [RW-1:0]        row_q;
  logic [CW-1:0]        col_q;
  logic                 value_q;
  logic                 res;
  logic [GRID_COLS-1:0] win_up;
  logic [GRID_COLS-1:0] win_mid;
  logic [GRID_COLS-1:0] win_dn;
  logic [GRID_COLS-1:0] row0_save;

  logic                 accept;
  logic                 res_load;
  logic                 addr_ok;
  logic                 edit_op;
  logic [RXW-1:0]       row_x;
  logic [CXW-1:0]       col_x;
  logic [RW-1:0]        row_idx;
  logic [CW-1:0]        col_idx;
  logic [TW-1:0]        t_m1;
  logic [TW-1:0]        t_m4;
  logic                 cur_bit;
  logic                 new_bit;
  logic [GRID_COLS-1:0] edit_row;
  logic [GRID_COLS-1:0] gen_row;

  logic                 rd_en;
  logic [RW-1:0]        rd_addr;
  logic [GRID_COLS-1:0] rd_data;
  logic                 wr_en;
  logic [RW-1:0]        wr_addr;
  logic [GRID_COLS-1:0] wr_data;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign res_load  = (state == S_DONE) && (!res_valid || res_ready);

  assign row_x   = RXW'(row);
  assign col_x   = CXW'(col);
  assign row_idx = row_x[RW-1:0];
  assign col_idx = col_x[CW-1:0];
  assign addr_ok = (32'(col) < 32'(GRID_COLS)) && (32'(row) < 32'(GRID_ROWS));
  assign edit_op = (cmd == lgse_pkg::CMD_TOGGLE) || (cmd == lgse_pkg::CMD_SET)
                || (cmd == lgse_pkg::CMD_READ);

  assign t_m1 = t - TW'(1);
  assign t_m4 = t - TW'(4);

  // Edit path: read-modify-write of one row
  always_comb begin
    cur_bit = rd_data[col_q];
    case (edit_cmd)
      lgse_pkg::CMD_TOGGLE: new_bit = ~cur_bit;
      lgse_pkg::CMD_SET:    new_bit = value_q;
      default:              new_bit = cur_bit;
    endcase
    edit_row        = rd_data;
    edit_row[col_q] = new_bit;
  end

  // Memory port steering
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = row_idx;
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_data = edit_row;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = t[RW-1:0];
        wr_data = '0;
      end
      S_IDLE: begin
        rd_en = accept && edit_op && addr_ok;
      end
      S_EDIT: begin
        wr_en = (edit_cmd != lgse_pkg::CMD_READ);
      end
      S_STEP: begin
        // read the last row first, then rows 0 .. GRID_ROWS-1
        rd_en   = (t <= TW'(GRID_ROWS));
        rd_addr = (t == '0) ? RW'(GRID_ROWS - 1) : t_m1[RW-1:0];
        wr_en   = (t >= TW'(4));
        wr_addr = t_m4[RW-1:0];
        wr_data = gen_row;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      t         <= '0;
      clr_cmd   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          res <= 1'b0;
          if (t == TW'(GRID_ROWS - 1)) begin
            t     <= '0;
            state <= clr_cmd ? S_DONE : S_IDLE;
          end else begin
            t <= t + TW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            edit_cmd <= lgse_pkg::cmd_t'(cmd);
            row_q    <= row_idx;
            col_q    <= col_idx;
            value_q  <= value;
            res      <= 1'b0;
            t        <= '0;
            case (cmd)
              lgse_pkg::CMD_CLEAR: begin
                clr_cmd <= 1'b1;
                state   <= S_CLEAR;
              end
              lgse_pkg::CMD_TOGGLE,
              lgse_pkg::CMD_SET,
              lgse_pkg::CMD_READ: begin
                state <= addr_ok ? S_EDIT : S_DONE;
              end
              lgse_pkg::CMD_ADVANCE: begin
                state <= S_STEP;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_EDIT: begin
          res   <= new_bit;
          state <= S_DONE;
        end
        S_STEP: begin
          t <= t + TW'(1);
          // advance the window; the saved old row 0 closes the wrap
          if ((t >= TW'(1)) && (t <= TW'(GRID_ROWS + 2))) begin
            win_up  <= win_mid;
            win_mid <= win_dn;
            win_dn  <= (t == TW'(GRID_ROWS + 2)) ? row0_save : rd_data;
          end
          if (t == TW'(2)) begin
            row0_save <= rd_data;
          end
          if (t == TW'(GRID_ROWS + 3)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_load) begin
            cell_state <= res;
            clr_cmd    <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  lgse_row_mem #(
    .ROWS (GRID_ROWS),
    .COLS (GRID_COLS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lgse_row_gen #(
    .COLS (GRID_COLS)
  ) u_gen (
    .row_up   (win_up),
    .row_mid  (win_mid),
    .row_dn   (win_dn),
    .row_next (gen_row)
  );

  a_no_rw_same_row: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("row read and written in the same cycle");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("grid written while idle");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> (!cmd_ready && (state == S_CLEAR)))
    else $error("command taken before reset clearing pass");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (t <= TW'(GRID_ROWS + 3)))
    else $error("generation sweep ran past last row");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the life grid step engine. A board model predicts
// the cell_state of every command word, and results are checked in order.
// A short directed sweep runs first. Random pattern bursts follow, each with
// sets and toggles in a small window, one to three generations and reads
// around the window. Noise words and random idling on both channels are mixed
// in, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GRID_COLS         = 64;
  localparam int GRID_ROWS         = 32;
  localparam int BIRTH_NEIGHBORS   = 3;
  localparam int SURVIVE_NEIGHBORS = 2;
  localparam int RANDOM_WORDS      = 650;
  localparam int IDLE_PCT          = 15;
  localparam int STEADY_FIRST      = 300;
  localparam int STEADY_LAST       = 420;
  localparam int HOLD_AFTER        = 150;
  localparam int HOLD_CYCLES       = 400;
  localparam int DRAIN_CYCLES      = GRID_ROWS + 16;
  localparam int CYCLE_LIMIT       = 400000;

  typedef struct {
    logic [lgse_pkg::CMD_W-1:0] op;
    int                         c;
    int                         r;
    bit                         state;
  } predicted_word_t;

  class life_board_model;
    bit [GRID_COLS-1:0] board [GRID_ROWS];
    predicted_word_t    awaiting [$];
    int                 mismatches;
    int                 words_checked;

    function void advance_generation();
      bit [GRID_COLS-1:0] nxt [GRID_ROWS];
      int up, dn, lf, rt, n;
      for (int r = 0; r < GRID_ROWS; r++) begin
        up = (r + GRID_ROWS - 1) % GRID_ROWS;
        dn = (r + 1) % GRID_ROWS;
        for (int c = 0; c < GRID_COLS; c++) begin
          lf = (c + GRID_COLS - 1) % GRID_COLS;
          rt = (c + 1) % GRID_COLS;
          n = int'(board[up][lf]) + int'(board[up][c]) + int'(board[up][rt]) +
              int'(board[r][lf]) + int'(board[r][rt]) +
              int'(board[dn][lf]) + int'(board[dn][c]) + int'(board[dn][rt]);
          if (n == BIRTH_NEIGHBORS) nxt[r][c] = 1'b1;
          else if (n == SURVIVE_NEIGHBORS) nxt[r][c] = board[r][c];
          else nxt[r][c] = 1'b0;
        end
      end
      board = nxt;
    endfunction

    function void apply_command(logic [lgse_pkg::CMD_W-1:0] op,
                                logic [lgse_pkg::COL_W-1:0] c,
                                logic [lgse_pkg::ROW_W-1:0] r, logic v);
      predicted_word_t w;
      bit in_grid;
      in_grid = (c < GRID_COLS) && (r < GRID_ROWS);
      w.op    = op;
      w.c     = c;
      w.r     = r;
      w.state = 1'b0;
      case (op)
        lgse_pkg::CMD_CLEAR: begin
          foreach (board[i]) board[i] = '0;
        end
        lgse_pkg::CMD_TOGGLE: begin
          if (in_grid) begin
            board[r][c] = ~board[r][c];
            w.state = board[r][c];
          end
        end
        lgse_pkg::CMD_SET: begin
          if (in_grid) begin
            board[r][c] = v;
            w.state = v;
          end
        end
        lgse_pkg::CMD_ADVANCE: begin
          advance_generation();
        end
        lgse_pkg::CMD_READ: begin
          if (in_grid) w.state = board[r][c];
        end
        default: begin
          // unknown opcodes leave the board alone and answer dead
        end
      endcase
      awaiting.push_back(w);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_cell_state(logic got);
      predicted_word_t w;
      words_checked++;
      if (awaiting.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with no command outstanding",
                                  words_checked));
      end else begin
        w = awaiting.pop_front();
        if (got !== w.state)
          report_mismatch($sformatf("word %0d op %0d row %0d col %0d: cell_state %b, want %b",
                                    words_checked, w.op, w.r, w.c, got, w.state));
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cmd_valid = 1'b0;
  logic                       cmd_ready;
  logic [lgse_pkg::CMD_W-1:0] cmd = '0;
  logic [lgse_pkg::COL_W-1:0] col = '0;
  logic [lgse_pkg::ROW_W-1:0] row = '0;
  logic                       value = 1'b0;
  logic                       res_valid;
  logic                       res_ready = 1'b0;
  logic                       cell_state;

  life_board_model life;
  int              commands_sent;
  int              cycles;
  bit              holdoff_done;

  life_grid_step_engine #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .col       (col),
    .row       (row),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cell_state(cell_state)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one command word and hold it until the engine takes it.
  task automatic send_command(input logic [lgse_pkg::CMD_W-1:0] op, input int c,
                              input int r, input bit v);
    bit steady;
    steady = (commands_sent >= STEADY_FIRST) && (commands_sent < STEADY_LAST);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_valid <= 1'b0;
      if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(4, 12)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= op;
    col       <= c[lgse_pkg::COL_W-1:0];
    row       <= r[lgse_pkg::ROW_W-1:0];
    value     <= v;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    commands_sent++;
  endtask

  always @(posedge clk) begin
    if (cmd_valid && cmd_ready === 1'b1) life.apply_command(cmd, col, row, value);
  end

  always @(posedge clk) begin
    if (res_valid === 1'b1 && res_ready) life.check_cell_state(cell_state);
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!holdoff_done && life.words_checked >= HOLD_AFTER) begin
        holdoff_done = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (life.words_checked >= STEADY_FIRST && life.words_checked < STEADY_LAST) begin
        res_ready <= 1'b1;
      end else begin
        res_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int r0, c0, span, directed_words;
    logic [lgse_pkg::CMD_W-1:0] op;
    life = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed sweep: field extremes, every opcode, wrap-around, ignored value
    send_command(lgse_pkg::CMD_READ,    0,  0, 1'b0);
    send_command(lgse_pkg::CMD_SET,     0,  0, 1'b1);
    send_command(lgse_pkg::CMD_SET,    63, 31, 1'b1);
    send_command(lgse_pkg::CMD_TOGGLE, 63,  0, 1'b0);
    send_command(lgse_pkg::CMD_TOGGLE,  0, 31, 1'b1);
    send_command(lgse_pkg::CMD_READ,   63, 31, 1'b1);
    send_command(lgse_pkg::CMD_READ + 3'd1, 63, 31, 1'b1);
    send_command(lgse_pkg::CMD_READ + 3'd2,  0,  0, 1'b0);
    send_command(lgse_pkg::CMD_READ + 3'd3, 42, 21, 1'b1);
    // four corners form one block across both seams; it must stay put
    send_command(lgse_pkg::CMD_ADVANCE, 63, 31, 1'b1);
    send_command(lgse_pkg::CMD_READ,    0,  0, 1'b0);
    send_command(lgse_pkg::CMD_READ,   63, 31, 1'b0);
    send_command(lgse_pkg::CMD_READ,    1,  1, 1'b0);
    send_command(lgse_pkg::CMD_CLEAR,  21, 10, 1'b1);
    send_command(lgse_pkg::CMD_READ,   63, 31, 1'b0);
    // blinker flips from horizontal to vertical
    send_command(lgse_pkg::CMD_SET,    10,  5, 1'b1);
    send_command(lgse_pkg::CMD_SET,    11,  5, 1'b1);
    send_command(lgse_pkg::CMD_SET,    12,  5, 1'b1);
    send_command(lgse_pkg::CMD_ADVANCE, 0,  0, 1'b0);
    send_command(lgse_pkg::CMD_READ,   11,  4, 1'b0);
    send_command(lgse_pkg::CMD_READ,   10,  5, 1'b1);
    send_command(lgse_pkg::CMD_READ,   11,  6, 1'b0);
    send_command(lgse_pkg::CMD_SET,    11,  4, 1'b0);
    directed_words = commands_sent;

    while (commands_sent < directed_words + RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 5) == 0)
          send_command(lgse_pkg::CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 31),
                       $urandom_range(0, 1));
        r0   = $urandom_range(0, GRID_ROWS - 1);
        c0   = $urandom_range(0, GRID_COLS - 1);
        span = $urandom_range(3, 8);
        repeat ($urandom_range(4, 2 * span + 4))
          send_command(($urandom_range(0, 3) == 0) ? lgse_pkg::CMD_TOGGLE
                                                   : lgse_pkg::CMD_SET,
                       (c0 + $urandom_range(0, span - 1)) % GRID_COLS,
                       (r0 + $urandom_range(0, span - 1)) % GRID_ROWS,
                       $urandom_range(0, 99) < 60);
        repeat ($urandom_range(1, 3))
          send_command(lgse_pkg::CMD_ADVANCE, $urandom_range(0, 63),
                       $urandom_range(0, 31), $urandom_range(0, 1));
        // probe the window plus a one-cell rim
        repeat ($urandom_range(4, 10))
          send_command(lgse_pkg::CMD_READ,
                       (c0 + GRID_COLS - 1 + $urandom_range(0, span + 1)) % GRID_COLS,
                       (r0 + GRID_ROWS - 1 + $urandom_range(0, span + 1)) % GRID_ROWS,
                       $urandom_range(0, 1));
      end else begin
        op = $urandom_range(0, 2 ** lgse_pkg::CMD_W - 1);
        if (op == lgse_pkg::CMD_CLEAR && $urandom_range(0, 3) != 0) op = lgse_pkg::CMD_READ;
        send_command(op, $urandom_range(0, 2 ** lgse_pkg::COL_W - 1),
                     $urandom_range(0, 2 ** lgse_pkg::ROW_W - 1), $urandom_range(0, 1));
      end
    end
    cmd_valid <= 1'b0;

    // let the monitor note the last accepted word before draining
    @(posedge clk);
    while (life.awaiting.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (life.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lgse_pkg.sv
rtl/lgse_row_mem.sv
rtl/lgse_row_gen.sv
rtl/life_grid_step_engine.sv
tb/testbench.sv
